/* sv/sfir_pkg.sv */
// Package for the symmetric 16-tap FIR filter.
// Holds default sizes, coefficient register reset values and the tap cell control type.
// Depends on nothing; every other file of the filter imports it.
`default_nettype none

package sfir_pkg;

	localparam int TAPS_DEFAULT         = 16;
	localparam int SAMPLE_WIDTH_DEFAULT = 16;

	// Coefficient registers are Q1.15; each serves a tap and its mirror.
	localparam int COEFF_WIDTH     = 16;
	localparam int NUM_COEFF       = 8;
	localparam int COEFF_IDX_W     = $clog2(NUM_COEFF);
	localparam int CFG_INDEX_WIDTH = 4;

	// Rounding to nearest before the Q1.15 scale is removed.
	localparam int ROUND_SHIFT = 15;
	localparam int ROUND_BIAS  = 1 << (ROUND_SHIFT - 1);

	typedef logic signed [COEFF_WIDTH-1:0] coeff_t;

	// Reset values of the low-pass table, rounded to Q1.15.
	localparam coeff_t COEFF_RESET [NUM_COEFF] = '{
		16'sd75, 16'sd167, 16'sd426, 16'sd898,
		16'sd1547, 16'sd2254, 16'sd2864, 16'sd3218
	};

	// Control for every tap cell in the chain.
	typedef struct packed {
		logic shift; // an item is accepted: the delay taps move one place
		logic load;  // the product stage takes new values
	} cell_ctrl_t;

endpackage

`default_nettype wire

/* sv/sfir_tap_cell.sv */
// One tap of the FIR chain: an optional delay register and a registered coefficient product.
// Depends on sfir_pkg for the coefficient type and the cell control struct.
`default_nettype none

module sfir_tap_cell
	import sfir_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT,
	parameter bit HAS_DELAY    = 1'b1
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire cell_ctrl_t                               ctrl,
	input  wire coeff_t                                   coeff,
	input  wire logic signed [SAMPLE_WIDTH-1:0]           x_in,
	output logic signed [SAMPLE_WIDTH-1:0]                x_out,
	output logic signed [SAMPLE_WIDTH+COEFF_WIDTH-1:0]    prod_s1
);

	localparam int PW = SAMPLE_WIDTH + COEFF_WIDTH;

	logic signed [PW-1:0] prod;

	// Full-precision product of this tap's sample and its coefficient.
	assign prod = x_in * coeff;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			prod_s1 <= prod;
		end
	end

	// The delay tap hands its sample to the next cell on every accepted item.
	generate
		if (HAS_DELAY) begin : g_delay
			logic signed [SAMPLE_WIDTH-1:0] x_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					x_q <= '0;
				end else if (ctrl.shift) begin
					x_q <= x_in;
				end
			end

			assign x_out = x_q;
		end else begin : g_no_delay
			assign x_out = '0;
		end
	endgenerate

endmodule

`default_nettype wire

/* sv/sfir_add_tree.sv */
// Registered binary adder tree that sums the tap products, one tree level per stage.
// Depends on sfir_pkg for the coefficient width.
`default_nettype none

module sfir_add_tree
	import sfir_pkg::*;
#(
	parameter int TAPS         = TAPS_DEFAULT,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT,
	localparam int LEVELS      = $clog2(TAPS),
	localparam int PW          = SAMPLE_WIDTH + COEFF_WIDTH,
	localparam int AW          = PW + LEVELS
) (
	input  wire logic                    clk,
	input  wire logic [LEVELS-1:0]       go_lvl,
	input  wire logic signed [PW-1:0]    prod [TAPS],
	output logic signed [AW-1:0]         root
);

	localparam int NPOW = 1 << LEVELS;

	logic signed [AW-1:0] leaf   [NPOW];
	logic signed [AW-1:0] node_q [NPOW-1];

	// Leaves past the last tap count as zero.
	generate
		for (genvar k = 0; k < NPOW; k++) begin : g_leaf
			if (k < TAPS) begin : g_used
				assign leaf[k] = AW'(prod[k]);
			end else begin : g_pad
				assign leaf[k] = '0;
			end
		end
	endgenerate

	// Node i has children 2i+1 and 2i+2; nodes of one depth form one stage.
	generate
		for (genvar i = 0; i < NPOW - 1; i++) begin : g_node
			localparam int D = $clog2(i + 2) - 1;
			logic signed [AW-1:0] lhs;
			logic signed [AW-1:0] rhs;

			if (2 * i + 1 >= NPOW - 1) begin : g_from_leaf
				assign lhs = leaf[2 * i + 1 - (NPOW - 1)];
				assign rhs = leaf[2 * i + 2 - (NPOW - 1)];
			end else begin : g_from_node
				assign lhs = node_q[2 * i + 1];
				assign rhs = node_q[2 * i + 2];
			end

			always_ff @(posedge clk) begin
				if (go_lvl[D]) begin
					node_q[i] <= lhs + rhs;
				end
			end
		end
	endgenerate

	assign root = node_q[0];

endmodule

`default_nettype wire

/* sv/symmetric_fir_16tap.sv */
// Symmetric FIR filter, direct form, Q1.15 coefficients, round and saturate.
// A result passes through the product register, which loads at the accepting edge,
// then one stage per adder tree level and one round and saturate stage.
// Throughput: one item per cycle unless the output stalls; each stage holds only while the stage after it is full.
// Reset clears the delay taps to zero, loads the low-pass coefficients and empties the pipe.
`default_nettype none

module symmetric_fir_16tap
	import sfir_pkg::*;
#(
	parameter int TAPS         = TAPS_DEFAULT,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Input item channel.
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  wire logic                          last_of_block,
	// Result item channel.
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]     sample_out,
	output logic                               block_end,
	// Coefficient write channel.
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  wire logic [COEFF_WIDTH-1:0]        cfg_data
);

	localparam int LEVELS = $clog2(TAPS);
	localparam int STAGES = LEVELS + 2;
	localparam int PW     = SAMPLE_WIDTH + COEFF_WIDTH;
	localparam int AW     = PW + LEVELS;
	localparam int RW     = AW + 1 - ROUND_SHIFT;

	localparam logic signed [RW-1:0] SAT_MAX =
		RW'((longint'(1) <<< (SAMPLE_WIDTH - 1)) - longint'(1));
	localparam logic signed [RW-1:0] SAT_MIN =
		RW'(-(longint'(1) <<< (SAMPLE_WIDTH - 1)));

	coeff_t                         coeff_q [NUM_COEFF];
	logic [STAGES-1:0]              valid_q;
	logic [STAGES-1:0]              last_q;
	logic [STAGES-1:0]              go;
	logic [LEVELS-1:0]              go_lvl;
	logic                           accept;
	cell_ctrl_t                     cell_ctrl;
	logic signed [SAMPLE_WIDTH-1:0] x_chain [TAPS];
	logic signed [PW-1:0]           prod_s1 [TAPS];
	logic signed [AW-1:0]           root;
	logic signed [AW:0]             biased;
	logic signed [RW-1:0]           scaled;
	logic signed [SAMPLE_WIDTH-1:0] sat;
	logic signed [SAMPLE_WIDTH-1:0] sample_out_q;

	// Coefficient registers; writes beyond the list are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_COEFF; j++) begin
				coeff_q[j] <= COEFF_RESET[j];
			end
		end else if (cfg_valid && (cfg_index < CFG_INDEX_WIDTH'(NUM_COEFF))) begin
			coeff_q[cfg_index[COEFF_IDX_W-1:0]] <= coeff_t'(cfg_data);
		end
	end

	// A stage may load when it is empty or its item moves on in the same cycle.
	always_comb begin
		go[STAGES-1] = !valid_q[STAGES-1] || out_ready;
		for (int i = STAGES - 2; i >= 0; i--) begin
			go[i] = !valid_q[i] || go[i + 1];
		end
		for (int d = 0; d < LEVELS; d++) begin
			go_lvl[d] = go[LEVELS - d];
		end
	end

	assign in_ready        = go[0];
	assign accept          = in_valid && in_ready;
	assign cell_ctrl.shift = accept;
	assign cell_ctrl.load  = go[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (go[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int i = 1; i < STAGES; i++) begin
				if (go[i]) begin
					valid_q[i] <= valid_q[i - 1];
				end
			end
		end
	end

	// The block-end flag travels alongside its item.
	always_ff @(posedge clk) begin
		if (go[0]) begin
			last_q[0] <= last_of_block;
		end
		for (int i = 1; i < STAGES; i++) begin
			if (go[i]) begin
				last_q[i] <= last_q[i - 1];
			end
		end
	end

	// Chain of tap cells: cell k sees x[n-k]; taps k and TAPS-1-k share a register.
	assign x_chain[0] = sample_in;

	generate
		for (genvar k = 0; k < TAPS; k++) begin : g_tap
			localparam int J = (k < TAPS - 1 - k) ? k : (TAPS - 1 - k);

			if (k < TAPS - 1) begin : g_mid
				sfir_tap_cell #(
					.SAMPLE_WIDTH (SAMPLE_WIDTH),
					.HAS_DELAY    (1'b1)
				) u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.ctrl    (cell_ctrl),
					.coeff   (coeff_q[J]),
					.x_in    (x_chain[k]),
					.x_out   (x_chain[k + 1]),
					.prod_s1 (prod_s1[k])
				);
			end else begin : g_end
				sfir_tap_cell #(
					.SAMPLE_WIDTH (SAMPLE_WIDTH),
					.HAS_DELAY    (1'b0)
				) u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.ctrl    (cell_ctrl),
					.coeff   (coeff_q[J]),
					.x_in    (x_chain[k]),
					.x_out   (),
					.prod_s1 (prod_s1[k])
				);
			end
		end
	endgenerate

	// Sum of all tap products.
	sfir_add_tree #(
		.TAPS         (TAPS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_tree (
		.clk    (clk),
		.go_lvl (go_lvl),
		.prod   (prod_s1),
		.root   (root)
	);

	// Round to nearest, drop the Q1.15 scale and clamp to the sample range.
	assign biased = {root[AW-1], root} + (AW + 1)'(ROUND_BIAS);
	assign scaled = biased[AW:ROUND_SHIFT];

	always_comb begin
		if (scaled > SAT_MAX) begin
			sat = SAT_MAX[SAMPLE_WIDTH-1:0];
		end else if (scaled < SAT_MIN) begin
			sat = SAT_MIN[SAMPLE_WIDTH-1:0];
		end else begin
			sat = scaled[SAMPLE_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (go[STAGES-1]) begin
			sample_out_q <= sat;
		end
	end

	assign out_valid  = valid_q[STAGES-1];
	assign block_end  = last_q[STAGES-1];
	assign sample_out = sample_out_q;

endmodule

`default_nettype wire
